// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker of the frame decoder.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SFCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define SFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfcc_pkg.sv =====
// Package for the sensor frame CRC check and conversion block.
// Holds codes, constants, the shared structs and the CRC-8 / divide helpers.
package sfcc_pkg;

  localparam int unsigned OffW   = 14;
  localparam int unsigned TempW  = 16;
  localparam int unsigned HumW   = 14;
  localparam int unsigned WordW  = 16;
  localparam int unsigned PosW   = 3;

  // Byte positions inside a frame
  localparam logic [PosW-1:0] POS_T_HI  = 3'd0;
  localparam logic [PosW-1:0] POS_T_LO  = 3'd1;
  localparam logic [PosW-1:0] POS_T_CRC = 3'd2;
  localparam logic [PosW-1:0] POS_H_HI  = 3'd3;
  localparam logic [PosW-1:0] POS_H_LO  = 3'd4;
  localparam logic [PosW-1:0] POS_H_CRC = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TEMP_BAD = 2'd1;
  localparam logic [1:0] ST_HUM_BAD  = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_TEMP_OFF = 1'b0;
  localparam logic REG_HUM_OFF  = 1'b1;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE  = 14'd10000;
  localparam logic signed [15:0] TEMP_BASE = -16'sd4500;
  localparam logic signed [15:0] HUM_MAX   = 16'sd10000;

  typedef struct packed {
    logic signed [OffW-1:0] temp_off;
    logic signed [OffW-1:0] hum_off;
  } cfg_t;

  typedef struct packed {
    logic             fire;
    logic [1:0]       status;
    logic [WordW-1:0] temp_word;
    logic [WordW-1:0] hum_word;
  } frame_res_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535), exact while the quotient stays below 2^16
  function automatic logic [15:0] div_ffff(input logic [31:0] x);
    logic [31:0] s;
    s = x + {16'd0, x[31:16]} + 32'd1;
    return s[31:16];
  endfunction

endpackage

// ===== rtl/sfcc_cfg.sv =====
// APB register file for the two calibration offsets.
// Depends on sfcc_pkg.
module sfcc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sfcc_pkg::cfg_t      cfg_o
);
  import sfcc_pkg::*;

  logic signed [OffW-1:0] temp_off_q, temp_off_d;
  logic signed [OffW-1:0] hum_off_q, hum_off_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    temp_off_d = temp_off_q;
    hum_off_d  = hum_off_q;
    if (wr_en) begin
      if (paddr[2] == REG_TEMP_OFF) temp_off_d = pwdata[OffW-1:0];
      else                          hum_off_d  = pwdata[OffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_off_q <= '0;
      hum_off_q  <= '0;
    end else begin
      temp_off_q <= temp_off_d;
      hum_off_q  <= hum_off_d;
    end
  end

  always_comb begin
    if (paddr[2] == REG_HUM_OFF) prdata = {{(32-OffW){hum_off_q[OffW-1]}}, hum_off_q};
    else                         prdata = {{(32-OffW){temp_off_q[OffW-1]}}, temp_off_q};
  end

  assign cfg_o.temp_off = temp_off_q;
  assign cfg_o.hum_off  = hum_off_q;

endmodule

// ===== rtl/sfcc_frame.sv =====
// Frame tracker: byte position, running CRC-8, captured words, temp CRC flag.
// Depends on sfcc_pkg.
module sfcc_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  output logic                  last_pending_o,
  output sfcc_pkg::frame_res_t  res_o
);
  import sfcc_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d, pos;
  logic [7:0]       crc_q, crc_d;
  logic [WordW-1:0] temp_q, temp_d;
  logic [WordW-1:0] hum_q, hum_d;
  logic             tbad_q, tbad_d;

  // frame start forces byte 0; unused codes fold to 0
  always_comb begin
    pos = pos_q;
    if (frame_start_i || pos_q > POS_H_CRC) pos = POS_T_HI;
  end

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    temp_d = temp_q;
    hum_d  = hum_q;
    tbad_d = tbad_q;
    if (accept_i) begin
      pos_d = pos + 3'd1;
      case (pos)
        POS_T_HI: begin
          crc_d  = crc8_feed(CRC_INIT, rx_byte_i);
          temp_d = {rx_byte_i, 8'd0};
        end
        POS_T_LO: begin
          crc_d  = crc8_feed(crc_q, rx_byte_i);
          temp_d = {temp_q[15:8], rx_byte_i};
        end
        POS_T_CRC: begin
          tbad_d = (crc_q != rx_byte_i);
          crc_d  = CRC_INIT;
        end
        POS_H_HI: begin
          crc_d = crc8_feed(CRC_INIT, rx_byte_i);
          hum_d = {rx_byte_i, 8'd0};
        end
        POS_H_LO: begin
          crc_d = crc8_feed(crc_q, rx_byte_i);
          hum_d = {hum_q[15:8], rx_byte_i};
        end
        default: begin
          // humidity CRC byte closes the frame
          pos_d = POS_T_HI;
          crc_d = CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_T_HI;
      crc_q  <= CRC_INIT;
      temp_q <= '0;
      hum_q  <= '0;
      tbad_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      temp_q <= temp_d;
      hum_q  <= hum_d;
      tbad_q <= tbad_d;
    end
  end

  assign last_pending_o = (pos_q == POS_H_CRC);

  always_comb begin
    res_o.fire      = accept_i && (pos == POS_H_CRC);
    res_o.temp_word = temp_q;
    res_o.hum_word  = hum_q;
    if (tbad_q)                  res_o.status = ST_TEMP_BAD;
    else if (crc_q != rx_byte_i) res_o.status = ST_HUM_BAD;
    else                         res_o.status = ST_OK;
  end

endmodule

// ===== rtl/sfcc_conv.sv =====
// Fixed-point conversion of the captured words and the result register.
// Depends on sfcc_pkg.
module sfcc_conv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfcc_pkg::frame_res_t        res_i,
  input  sfcc_pkg::cfg_t              cfg_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [1:0]                  frame_status_o,
  output logic signed [sfcc_pkg::TempW-1:0] temperature_centi_o,
  output logic [sfcc_pkg::HumW-1:0]   humidity_centi_o,
  output logic [sfcc_pkg::WordW-1:0]  temperature_raw_o,
  output logic [sfcc_pkg::WordW-1:0]  humidity_raw_o
);
  import sfcc_pkg::*;

  logic [30:0]             t_prod;
  logic [29:0]             h_prod;
  logic [15:0]             t_quo, h_quo;
  logic signed [15:0]      t_sum, h_sum;
  logic signed [TempW-1:0] temp_d;
  logic [HumW-1:0]         hum_d;

  logic                    valid_q, valid_d;
  logic [1:0]              status_q;
  logic signed [TempW-1:0] temp_q;
  logic [HumW-1:0]         hum_q;
  logic [WordW-1:0]        traw_q, hraw_q;

  // constant multiply, then exact floor divide by 65535
  assign t_prod = 31'(res_i.temp_word) * 31'(TEMP_SCALE);
  assign h_prod = 30'(res_i.hum_word) * 30'(HUM_SCALE);
  assign t_quo  = div_ffff(32'(t_prod));
  assign h_quo  = div_ffff(32'(h_prod));

  assign t_sum = $signed(t_quo) + TEMP_BASE
               + $signed({{(16-OffW){cfg_i.temp_off[OffW-1]}}, cfg_i.temp_off});
  assign h_sum = $signed(h_quo)
               + $signed({{(16-OffW){cfg_i.hum_off[OffW-1]}}, cfg_i.hum_off});

  always_comb begin
    temp_d = '0;
    hum_d  = '0;
    if (res_i.status == ST_OK) begin
      temp_d = t_sum;
      if (h_sum < 16'sd0)        hum_d = '0;
      else if (h_sum > HUM_MAX)  hum_d = HUM_MAX[HumW-1:0];
      else                       hum_d = h_sum[HumW-1:0];
    end
  end

  assign valid_d = res_i.fire | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (res_i.fire) begin
      status_q <= res_i.status;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      traw_q   <= res_i.temp_word;
      hraw_q   <= res_i.hum_word;
    end
  end

  assign out_valid_o         = valid_q;
  assign frame_status_o      = status_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign temperature_raw_o   = traw_q;
  assign humidity_raw_o      = hraw_q;

endmodule

// ===== rtl/sensor_frame_crc_convert.sv =====
// Top level of the sensor frame CRC check and conversion block.
// Depends on sfcc_pkg, sfcc_cfg, sfcc_frame and sfcc_conv.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------------
//   in       | input     | in_valid_i / in_stall_o | rx_byte_i, frame_start_i
//   out      | output    | out_valid_o / out_stall_i | frame_status_o, temperature_centi_o,
//            |           |                        | humidity_centi_o, *_raw_o
//   cfg      | input     | APB psel/penable/pready | temp offset @0x0, hum offset @0x4
//
// One byte per cycle while in_stall_o is low. The result of a frame sits in the
// output register in the cycle after its sixth byte is taken; CRC update is a single
// byte step and the conversion is a constant multiply with a shift-add divide by 65535.
// in_stall_o rises only when a sixth byte is due while the output register still
// holds an untaken transaction, also for a byte with frame_start_i; all other bytes pass.
// Reset clears byte position, captured words, the temperature CRC flag, offsets
// and out valid, and loads the CRC with 0xFF.
module sensor_frame_crc_convert (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // byte input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         rx_byte_i,
  input  logic                               frame_start_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         frame_status_o,
  output logic signed [sfcc_pkg::TempW-1:0]  temperature_centi_o,
  output logic [sfcc_pkg::HumW-1:0]          humidity_centi_o,
  output logic [sfcc_pkg::WordW-1:0]         temperature_raw_o,
  output logic [sfcc_pkg::WordW-1:0]         humidity_raw_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import sfcc_pkg::*;

  cfg_t       cfg;
  frame_res_t res;
  logic       last_pending;
  logic       in_accept;

  // Only a frame-closing byte needs the output slot.
  assign in_stall_o = out_valid_o & out_stall_i & last_pending;
  assign in_accept  = in_valid_i & ~in_stall_o;

  sfcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfcc_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .last_pending_o (last_pending),
    .res_o          (res)
  );

  sfcc_conv u_conv (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .res_i               (res),
    .cfg_i               (cfg),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .frame_status_o      (frame_status_o),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_raw_o   (temperature_raw_o),
    .humidity_raw_o      (humidity_raw_o)
  );

endmodule

// ===== rtl/sfcc_checker.sv =====
// Port-level checker for the frame decoder, bound to the top level.
// Depends on sfcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfcc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              frame_start_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [1:0]                        frame_status_o,
  input logic signed [sfcc_pkg::TempW-1:0] temperature_centi_o,
  input logic [sfcc_pkg::HumW-1:0]         humidity_centi_o,
  input logic [sfcc_pkg::WordW-1:0]        temperature_raw_o
);
  import sfcc_pkg::*;

  `SFCC_ASSERT_NOW(a_err_zeroes, out_valid_o && frame_status_o != ST_OK,
    temperature_centi_o == '0 && humidity_centi_o == '0,
    "converted values not zero on CRC error")

  `SFCC_ASSERT_NOW(a_hum_clamp, out_valid_o, humidity_centi_o <= HUM_MAX[HumW-1:0],
    "humidity above full scale")

  `SFCC_ASSERT_NOW(a_new_result_src, out_valid_o && !$past(out_valid_o),
    $past(in_valid_i && !in_stall_o), "result without a closing byte")

  `SFCC_ASSERT_NEXT(a_start_no_result, in_valid_i && !in_stall_o && frame_start_i,
    !$rose(out_valid_o), "result after a frame start byte")

  `SFCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(frame_status_o) && $stable(temperature_raw_o),
    "stalled result changed")

endmodule

bind sensor_frame_crc_convert sfcc_checker u_sfcc_checker (.*);
